[hdl/lhc_pkg.sv]
package lhc_pkg;

  localparam int Capacity = 32;
  localparam int IdxW = $clog2(Capacity);
  localparam int OccW = 6;

  typedef enum logic [2:0] {
    CMD_GET    = 3'd0,
    CMD_PUT    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_RSTAT  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_MISS     = 2'd0,
    ST_HIT      = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_DONE     = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] key_upper;
    logic [63:0] key_lower;
    logic [3:0]  kind_tag;
    logic [63:0] handle_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] handle_out;
    logic        release_valid;
    logic [63:0] release_handle;
    logic [3:0]  release_kind;
    logic [63:0] hit_total;
    logic [63:0] miss_total;
    logic [63:0] eviction_total;
    logic [63:0] insertion_total;
    logic [OccW-1:0] occupancy;
    logic        last_result;
  } rsp_t;

endpackage

[hdl/lhc_req_fifo.sv]
module lhc_req_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lhc_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lhc_pkg::req_t out_data_o
);
  lhc_pkg::req_t mem_q [2];
  logic [1:0] wp_q, rp_q;
  logic push, pop;

  assign in_ready_o  = (wp_q - rp_q) != 2'd2;
  assign out_valid_o = wp_q != rp_q;
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;
  assign out_data_o = mem_q[rp_q[0]];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q[0]] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 2'd1;
      if (pop) rp_q <= rp_q + 2'd1;
    end
  end
endmodule

[hdl/lhc_engine.sv]
module lhc_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [5:0]    limit_i,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  lhc_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output lhc_pkg::rsp_t rsp_o
);
  localparam int N = lhc_pkg::Capacity;
  localparam int IW = lhc_pkg::IdxW;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_OUT   = 4'b1000
  } state_e;

  state_e state_q;
  lhc_pkg::req_t req_q;
  logic [63:0] ku_q [N];
  logic [63:0] kl_q [N];
  logic [63:0] hd_q [N];
  logic [3:0]  kd_q [N];
  logic [N-1:0] vld_q;
  logic [IW-1:0] rank_q [N];
  logic [63:0] hit_q, miss_q, evc_q, ins_q;
  logic [lhc_pkg::OccW-1:0] occ_q;
  logic [N-1:0] match_q;
  lhc_pkg::rsp_t rsp_q;
  logic [IW-1:0] lim_m1;

  // lookup results, from registered match vector
  logic found;
  logic [IW-1:0] fidx, free_idx, lru_idx, mru_idx;
  logic has_free;
  always_comb begin
    found = 1'b0; fidx = '0; has_free = 1'b0; free_idx = '0;
    lru_idx = '0; mru_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (match_q[i]) begin found = 1'b1; fidx = IW'(i); end
      if (!vld_q[i]) begin has_free = 1'b1; free_idx = IW'(i); end
    end
    for (int i = 0; i < N; i++) begin
      if (vld_q[i] && rank_q[i] == IW'(occ_q - 6'd1)) lru_idx = IW'(i);
      if (vld_q[i] && rank_q[i] == '0) mru_idx = IW'(i);
    end
  end

  always_comb begin
    if (limit_i == 6'd0) lim_m1 = '0;
    else if (limit_i > 6'(N)) lim_m1 = IW'(N - 1);
    else lim_m1 = IW'(limit_i - 6'd1);
  end

  assign req_ready_o = state_q == S_IDLE;
  assign rsp_valid_o = state_q == S_OUT;
  assign rsp_o = rsp_q;

  lhc_pkg::rsp_t base;
  always_comb begin
    base = '0;
    base.status = lhc_pkg::ST_DONE;
    base.hit_total = hit_q;
    base.miss_total = miss_q;
    base.eviction_total = evc_q;
    base.insertion_total = ins_q;
    base.occupancy = occ_q;
    base.last_result = 1'b1;
  end

  function automatic lhc_pkg::rsp_t set_rel(lhc_pkg::rsp_t r, logic [63:0] h, logic [3:0] k);
    lhc_pkg::rsp_t o;
    o = r;
    o.release_valid = h != '0;
    o.release_handle = (h != '0) ? h : '0;
    o.release_kind = (h != '0) ? k : '0;
    return o;
  endfunction

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) req_q <= req_i;
    if (state_q == S_SCAN) begin
      for (int i = 0; i < N; i++)
        match_q[i] <= vld_q[i] && ku_q[i] == req_q.key_upper && kl_q[i] == req_q.key_lower;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vld_q <= '0;
      for (int i = 0; i < N; i++) rank_q[i] <= '0;
      hit_q <= '0; miss_q <= '0; evc_q <= '0; ins_q <= '0;
      occ_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (req_valid_i) state_q <= S_SCAN;
        S_SCAN: state_q <= S_EXEC;
        S_EXEC: begin
          lhc_pkg::rsp_t r;
          logic ev;
          logic [IW-1:0] slot, d;
          state_q <= S_OUT;
          r = base;
          ev = 1'b0;
          slot = '0;
          d = '0;
          unique case (req_q.command)
            lhc_pkg::CMD_GET: begin
              if (!found) begin
                miss_q <= miss_q + 64'd1;
                r.miss_total = miss_q + 64'd1;
                r.status = lhc_pkg::ST_MISS;
              end else begin
                hit_q <= hit_q + 64'd1;
                r.hit_total = hit_q + 64'd1;
                if (kd_q[fidx] != req_q.kind_tag) begin
                  r.status = lhc_pkg::ST_MISMATCH;
                end else begin
                  r.status = lhc_pkg::ST_HIT;
                  r.handle_out = hd_q[fidx];
                  for (int i = 0; i < N; i++)
                    if (vld_q[i] && rank_q[i] < rank_q[fidx]) rank_q[i] <= rank_q[i] + 1'b1;
                  rank_q[fidx] <= '0;
                end
              end
            end
            lhc_pkg::CMD_PUT: begin
              if (found) begin
                r = set_rel(base, hd_q[fidx], kd_q[fidx]);
                hd_q[fidx] <= req_q.handle_in;
                kd_q[fidx] <= req_q.kind_tag;
                for (int i = 0; i < N; i++)
                  if (vld_q[i] && rank_q[i] < rank_q[fidx]) rank_q[i] <= rank_q[i] + 1'b1;
                rank_q[fidx] <= '0;
              end else begin
                ev = occ_q != '0 && occ_q > {1'b0, lim_m1};
                slot = ev ? lru_idx : free_idx;
                if (ev) begin
                  r = set_rel(base, hd_q[lru_idx], kd_q[lru_idx]);
                  evc_q <= evc_q + 64'd1;
                  r.eviction_total = evc_q + 64'd1;
                end
                // evicted slot is lowest free only if lower than other free slots
                if (ev && has_free && free_idx < lru_idx) slot = free_idx;
                for (int i = 0; i < N; i++)
                  if (vld_q[i] && !(ev && IW'(i) == lru_idx)) rank_q[i] <= rank_q[i] + 1'b1;
                if (ev || has_free) begin
                  if (ev && slot != lru_idx) vld_q[lru_idx] <= 1'b0;
                  vld_q[slot] <= 1'b1;
                  ku_q[slot] <= req_q.key_upper;
                  kl_q[slot] <= req_q.key_lower;
                  hd_q[slot] <= req_q.handle_in;
                  kd_q[slot] <= req_q.kind_tag;
                  rank_q[slot] <= '0;
                  ins_q <= ins_q + 64'd1;
                  r.insertion_total = ins_q + 64'd1;
                  occ_q <= ev ? occ_q : occ_q + 6'd1;
                  r.occupancy = ev ? occ_q : occ_q + 6'd1;
                end
              end
            end
            lhc_pkg::CMD_REMOVE, lhc_pkg::CMD_CLEAR: begin
              d = (req_q.command == lhc_pkg::CMD_CLEAR) ? mru_idx : fidx;
              if ((req_q.command == lhc_pkg::CMD_CLEAR) ? (occ_q != '0) : found) begin
                r = set_rel(base, hd_q[d], kd_q[d]);
                vld_q[d] <= 1'b0;
                rank_q[d] <= '0;
                for (int i = 0; i < N; i++)
                  if (vld_q[i] && rank_q[i] > rank_q[d]) rank_q[i] <= rank_q[i] - 1'b1;
                occ_q <= occ_q - 6'd1;
                r.occupancy = occ_q - 6'd1;
                if (req_q.command == lhc_pkg::CMD_CLEAR) r.last_result = occ_q == 6'd1;
              end
            end
            lhc_pkg::CMD_RSTAT: begin
              hit_q <= '0; miss_q <= '0; evc_q <= '0; ins_q <= '0;
              r.hit_total = '0; r.miss_total = '0;
              r.eviction_total = '0; r.insertion_total = '0;
            end
            default: ;
          endcase
          rsp_q <= r;
        end
        S_OUT: if (rsp_ready_i) state_q <= rsp_q.last_result ? S_IDLE : S_EXEC;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

[hdl/lru_handle_cache_top.sv]
// Fully associative LRU handle cache, 32 entries, 128-bit keys.
// Request channel: in_valid_i/in_ready_o with command, key, kind_tag,
// handle_in. Result channel: out_valid_o/out_ready_i; last_result marks
// the final result of a request. entry_limit is written with cfg_we_i;
// the user must do so only while the block is idle (not enforced here).
// A two-entry request queue sits in front of the execution engine, so
// requests are taken while a result waits.
// Each request takes the engine through its states: accept from the queue
// (idle), key compare, execute (lookup decode, recency update, writeback)
// and result, where it stays until the result is taken. Clear gives one
// result per valid entry (a single result when empty), most recent first.
// Reset empties the cache, zeros counters and sets entry_limit to 32.
// A stalled receiver holds the result; the engine waits and the queue
// fills, then in_ready_o drops.
module lru_handle_cache_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [63:0] key_upper_i,
  input  logic [63:0] key_lower_i,
  input  logic [3:0]  kind_tag_i,
  input  logic [63:0] handle_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [63:0] handle_out_o,
  output logic        release_valid_o,
  output logic [63:0] release_handle_o,
  output logic [3:0]  release_kind_o,
  output logic [63:0] hit_total_o,
  output logic [63:0] miss_total_o,
  output logic [63:0] eviction_total_o,
  output logic [63:0] insertion_total_o,
  output logic [5:0]  occupancy_o,
  output logic        last_result_o
);
  logic [5:0] limit_q;
  lhc_pkg::req_t in_req, q_req;
  lhc_pkg::rsp_t rsp;
  logic q_valid, q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= 6'd32;
    else if (cfg_we_i) limit_q <= cfg_wdata_i;
  end

  assign in_req = '{command: command_i, key_upper: key_upper_i, key_lower: key_lower_i,
                    kind_tag: kind_tag_i, handle_in: handle_in_i};

  lhc_req_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_data_i(in_req),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_data_o(q_req)
  );

  lhc_engine u_engine (
    .clk_i, .rst_ni, .limit_i(limit_q),
    .req_valid_i(q_valid), .req_ready_o(q_ready), .req_i(q_req),
    .rsp_valid_o(out_valid_o), .rsp_ready_i(out_ready_i), .rsp_o(rsp)
  );

  assign status_o          = rsp.status;
  assign handle_out_o      = rsp.handle_out;
  assign release_valid_o   = rsp.release_valid;
  assign release_handle_o  = rsp.release_handle;
  assign release_kind_o    = rsp.release_kind;
  assign hit_total_o       = rsp.hit_total;
  assign miss_total_o      = rsp.miss_total;
  assign eviction_total_o  = rsp.eviction_total;
  assign insertion_total_o = rsp.insertion_total;
  assign occupancy_o       = rsp.occupancy;
  assign last_result_o     = rsp.last_result;

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occupancy_o <= 6'd32) else $error("occupancy out of range");
  a_rel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !release_valid_o |-> release_handle_o == '0)
    else $error("release handle without valid");
  a_hit_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != lhc_pkg::ST_HIT |-> handle_out_o == '0)
    else $error("handle on non-hit");
endmodule

[test/lhc_checker.sv]
`timescale 1ns / 100ps

module lhc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [63:0] key_upper_i,
  input  logic [63:0] key_lower_i,
  input  logic [3:0]  kind_tag_i,
  input  logic [63:0] handle_in_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [1:0]  status_o,
  input  logic [63:0] handle_out_o,
  input  logic        release_valid_o,
  input  logic [63:0] release_handle_o,
  input  logic [3:0]  release_kind_o,
  input  logic [63:0] hit_total_o,
  input  logic [63:0] miss_total_o,
  input  logic [63:0] eviction_total_o,
  input  logic [63:0] insertion_total_o,
  input  logic [5:0]  occupancy_o,
  input  logic        last_result_o,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);

  logic [63:0] c_ku [lhc_pkg::Capacity];
  logic [63:0] c_kl [lhc_pkg::Capacity];
  logic [63:0] c_h [lhc_pkg::Capacity];
  logic [3:0]  c_kind [lhc_pkg::Capacity];
  logic        c_v [lhc_pkg::Capacity];
  int          c_rank [lhc_pkg::Capacity];
  logic [63:0] n_hit, n_miss, n_evict, n_ins;
  int          n_occ;
  logic [5:0]  limit_reg;
  lhc_pkg::rsp_t expected_q [$];

  assign pending_count = expected_q.size();

  function automatic int find_entry(logic [63:0] ku, logic [63:0] kl);
    for (int i = 0; i < lhc_pkg::Capacity; i++)
      if (c_v[i] && c_ku[i] == ku && c_kl[i] == kl) return i;
    return -1;
  endfunction

  function automatic void promote(int idx);
    for (int i = 0; i < lhc_pkg::Capacity; i++)
      if (c_v[i] && i != idx && c_rank[i] < c_rank[idx]) c_rank[i]++;
    c_rank[idx] = 0;
  endfunction

  function automatic void drop(int idx);
    int r;
    r = c_rank[idx];
    c_v[idx] = 1'b0;
    c_rank[idx] = 0;
    for (int i = 0; i < lhc_pkg::Capacity; i++)
      if (c_v[i] && c_rank[i] > r) c_rank[i]--;
    if (n_occ > 0) n_occ--;
  endfunction

  function automatic void push_rsp(lhc_pkg::status_e st, logic [63:0] hout, logic [63:0] rh,
                                   logic [3:0] rk);
    lhc_pkg::rsp_t r;
    r.status = st;
    r.handle_out = hout;
    r.release_valid = rh != '0;
    r.release_handle = rh;
    r.release_kind = (rh != '0) ? rk : 4'd0;
    r.hit_total = n_hit;
    r.miss_total = n_miss;
    r.eviction_total = n_evict;
    r.insertion_total = n_ins;
    r.occupancy = n_occ[5:0];
    r.last_result = 1'b0;
    expected_q.push_back(r);
  endfunction

  function automatic void predict_request(lhc_pkg::req_t q);
    int idx, lim, best, issued;
    logic [63:0] rh, oh;
    logic [3:0]  rk, ok;
    issued = 0;
    idx = find_entry(q.key_upper, q.key_lower);
    case (q.command)
      lhc_pkg::CMD_GET: begin
        if (idx < 0) begin
          n_miss++;
          push_rsp(lhc_pkg::ST_MISS, '0, '0, '0);
        end else begin
          n_hit++;
          if (c_kind[idx] != q.kind_tag) push_rsp(lhc_pkg::ST_MISMATCH, '0, '0, '0);
          else begin
            promote(idx);
            push_rsp(lhc_pkg::ST_HIT, c_h[idx], '0, '0);
          end
        end
      end
      lhc_pkg::CMD_PUT: begin
        if (idx >= 0) begin
          oh = c_h[idx];
          ok = c_kind[idx];
          c_h[idx] = q.handle_in;
          c_kind[idx] = q.kind_tag;
          promote(idx);
          push_rsp(lhc_pkg::ST_DONE, '0, oh, ok);
        end else begin
          rh = '0;
          rk = '0;
          lim = int'(limit_reg);
          if (lim < 1) lim = 1;
          if (lim > lhc_pkg::Capacity) lim = lhc_pkg::Capacity;
          if (n_occ >= lim) begin
            best = -1;
            for (int i = 0; i < lhc_pkg::Capacity; i++)
              if (c_v[i] && (best < 0 || c_rank[i] > c_rank[best])) best = i;
            if (best >= 0) begin
              rh = c_h[best];
              rk = c_kind[best];
              drop(best);
              n_evict++;
            end
          end
          for (int i = 0; i < lhc_pkg::Capacity; i++) if (c_v[i]) c_rank[i]++;
          idx = 0;
          while (idx < lhc_pkg::Capacity && c_v[idx]) idx++;
          if (idx < lhc_pkg::Capacity) begin
            c_v[idx] = 1'b1;
            c_ku[idx] = q.key_upper;
            c_kl[idx] = q.key_lower;
            c_h[idx] = q.handle_in;
            c_kind[idx] = q.kind_tag;
            c_rank[idx] = 0;
            n_occ++;
            n_ins++;
          end
          push_rsp(lhc_pkg::ST_DONE, '0, rh, rk);
        end
      end
      lhc_pkg::CMD_REMOVE: begin
        if (idx >= 0) begin
          oh = c_h[idx];
          ok = c_kind[idx];
          drop(idx);
          push_rsp(lhc_pkg::ST_DONE, '0, oh, ok);
        end else push_rsp(lhc_pkg::ST_DONE, '0, '0, '0);
      end
      lhc_pkg::CMD_CLEAR: begin
        while (n_occ > 0) begin
          best = -1;
          for (int i = 0; i < lhc_pkg::Capacity; i++)
            if (c_v[i] && (best < 0 || c_rank[i] < c_rank[best])) best = i;
          if (best < 0) begin
            n_occ = 0;
            break;
          end
          oh = c_h[best];
          ok = c_kind[best];
          drop(best);
          push_rsp(lhc_pkg::ST_DONE, '0, oh, ok);
          issued++;
        end
        if (issued == 0) push_rsp(lhc_pkg::ST_DONE, '0, '0, '0);
      end
      lhc_pkg::CMD_RSTAT: begin
        n_hit = '0;
        n_miss = '0;
        n_evict = '0;
        n_ins = '0;
        push_rsp(lhc_pkg::ST_DONE, '0, '0, '0);
      end
      default: push_rsp(lhc_pkg::ST_DONE, '0, '0, '0);
    endcase
    expected_q[$].last_result = 1'b1;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lhc_pkg::rsp_t e;
    lhc_pkg::req_t q;
    if (!rst_ni) begin
      for (int i = 0; i < lhc_pkg::Capacity; i++) begin
        c_v[i] = 1'b0;
        c_rank[i] = 0;
      end
      n_hit = '0;
      n_miss = '0;
      n_evict = '0;
      n_ins = '0;
      n_occ = 0;
      limit_reg = 6'd32;
      expected_q.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        result_count++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected item, status %0d", $time, status_o);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          check_field("status", 64'(e.status), 64'(status_o));
          check_field("handle_out", e.handle_out, handle_out_o);
          check_field("release_valid", 64'(e.release_valid), 64'(release_valid_o));
          check_field("release_handle", e.release_handle, release_handle_o);
          check_field("release_kind", 64'(e.release_kind), 64'(release_kind_o));
          check_field("hit_total", e.hit_total, hit_total_o);
          check_field("miss_total", e.miss_total, miss_total_o);
          check_field("eviction_total", e.eviction_total, eviction_total_o);
          check_field("insertion_total", e.insertion_total, insertion_total_o);
          check_field("occupancy", 64'(e.occupancy), 64'(occupancy_o));
          check_field("last_result", 64'(e.last_result), 64'(last_result_o));
        end
      end
      if (cfg_we_i) limit_reg = cfg_wdata_i;
      if (in_valid_i && in_ready_o) begin
        q.command = command_i;
        q.key_upper = key_upper_i;
        q.key_lower = key_lower_i;
        q.kind_tag = kind_tag_i;
        q.handle_in = handle_in_i;
        predict_request(q);
      end
    end
  end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam int StallLimit = 20000;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [5:0]  cfg_wdata_i;
  logic        in_valid_i, in_ready_o;
  logic [2:0]  command_i;
  logic [63:0] key_upper_i, key_lower_i, handle_in_i;
  logic [3:0]  kind_tag_i;
  logic        out_valid_o, out_ready_i;
  logic [1:0]  status_o;
  logic [63:0] handle_out_o, release_handle_o;
  logic        release_valid_o;
  logic [3:0]  release_kind_o;
  logic [63:0] hit_total_o, miss_total_o, eviction_total_o, insertion_total_o;
  logic [5:0]  occupancy_o;
  logic        last_result_o;
  int          fail_count, pending_count, result_count;
  int          sent_count, idle_cycles;
  bit          stall_on;
  logic [63:0] key_pool_u [8];
  logic [63:0] key_pool_l [8];

  lru_handle_cache_top dut (.*);
  lhc_checker chk (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver stall pattern: alternating bursts of ready and stall
  always @(negedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b1;
    else begin
      if ($urandom_range(0, 15) == 0) stall_on = !stall_on && $urandom_range(0, 2) != 0;
      out_ready_i <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else if (pending_count > 0 || in_valid_i) idle_cycles <= idle_cycles + 1;
    else idle_cycles <= 0;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog expired");
      $display("lru_handle_cache_top test failed");
      $finish;
    end
  end

  task automatic send_item(logic [2:0] cmd, logic [63:0] ku, logic [63:0] kl,
                           logic [3:0] kind, logic [63:0] h);
    in_valid_i <= 1'b1;
    command_i <= cmd;
    key_upper_i <= ku;
    key_lower_i <= kl;
    kind_tag_i <= kind;
    handle_in_i <= h;
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
    @(negedge clk_i);
    if ($urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  task automatic drain_then_config(logic [5:0] lim);
    in_valid_i <= 1'b0;
    while (pending_count > 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= lim;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_item();
    int p, sel;
    logic [2:0] cmd;
    logic [63:0] h;
    p = $urandom_range(0, 99);
    sel = $urandom_range(0, 7);
    h = $urandom_range(0, 5) == 0 ? 64'd0 : {$urandom, $urandom};
    if (p < 35) cmd = lhc_pkg::CMD_GET;
    else if (p < 75) cmd = lhc_pkg::CMD_PUT;
    else if (p < 88) cmd = lhc_pkg::CMD_REMOVE;
    else if (p < 92) cmd = lhc_pkg::CMD_CLEAR;
    else if (p < 96) cmd = lhc_pkg::CMD_RSTAT;
    else cmd = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 4) == 0)
      send_item(cmd, {$urandom, $urandom}, {$urandom, $urandom},
                4'($urandom), h);
    else
      send_item(cmd, key_pool_u[sel], key_pool_l[sel], 4'($urandom_range(0, 3)), h);
  endtask

  initial begin
    logic [5:0] limits [6];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    command_i = lhc_pkg::CMD_GET;
    key_upper_i = '0;
    key_lower_i = '0;
    kind_tag_i = '0;
    handle_in_i = '0;
    sent_count = 0;
    for (int i = 0; i < 8; i++) begin
      key_pool_u[i] = {$urandom, $urandom};
      key_pool_l[i] = {$urandom, $urandom};
    end
    key_pool_u[0] = '1;
    key_pool_l[0] = '1;
    key_pool_u[1] = '0;
    key_pool_l[1] = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, mismatch, replace, eviction, remove, clear, unknown
    send_item(lhc_pkg::CMD_CLEAR, '0, '0, '0, '0);
    send_item(lhc_pkg::CMD_GET, '1, '1, 4'hf, '0);
    send_item(lhc_pkg::CMD_PUT, '1, '1, 4'hf, '1);
    send_item(lhc_pkg::CMD_PUT, '0, '0, 4'h0, '0);
    send_item(lhc_pkg::CMD_GET, '1, '1, 4'hf, '0);
    send_item(lhc_pkg::CMD_GET, '1, '1, 4'h0, '0);
    send_item(lhc_pkg::CMD_PUT, '1, '1, 4'h5, 64'h5555_aaaa_5555_aaaa);
    send_item(lhc_pkg::CMD_PUT, '1, '1, 4'ha, 64'haaaa_5555_aaaa_5555);
    send_item(lhc_pkg::CMD_REMOVE, '0, '0, '0, '0);
    send_item(lhc_pkg::CMD_REMOVE, 64'h1234, 64'h5678, '0, '0);
    send_item(3'd7, '1, '1, 4'hf, '1);
    send_item(3'd5, '0, '0, '0, '0);
    send_item(lhc_pkg::CMD_RSTAT, '0, '0, '0, '0);
    send_item(lhc_pkg::CMD_CLEAR, '0, '0, '0, '0);
    drain_then_config(6'd1);
    send_item(lhc_pkg::CMD_PUT, key_pool_u[2], key_pool_l[2], 4'h1, 64'h11);
    send_item(lhc_pkg::CMD_PUT, key_pool_u[3], key_pool_l[3], 4'h2, 64'h22);
    send_item(lhc_pkg::CMD_GET, key_pool_u[2], key_pool_l[2], 4'h1, '0);
    drain_then_config(6'd0);
    send_item(lhc_pkg::CMD_PUT, key_pool_u[4], key_pool_l[4], 4'h3, '0);
    drain_then_config(6'd63);
    for (int i = 0; i < 33; i++)
      send_item(lhc_pkg::CMD_PUT, 64'(i), ~64'(i), 4'(i), {$urandom, $urandom});
    send_item(lhc_pkg::CMD_CLEAR, '0, '0, '0, '0);

    limits = '{6'd32, 6'd3, 6'd1, 6'd8, 6'd40, 6'd5};
    foreach (limits[k]) begin
      drain_then_config(limits[k]);
      for (int i = 0; i < 40; i++) random_item();
    end
    in_valid_i <= 1'b0;
    while (pending_count > 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("sent %0d request items, checked %0d result items", sent_count, result_count);
    $display("limits swept 0..63 with replace, eviction, clear and type mismatch cases");
    if (fail_count == 0) $display("lru_handle_cache_top test passed");
    else $display("lru_handle_cache_top test failed");
    $finish;
  end

endmodule
